/* src/cqg_pkg.sv */
// ----------------------------------------------------------------------------
// cqg_pkg: shared types and constants for the cell quadrature geometry block
// Payload structs, the queued cell job and the Gauss point coefficient table.
// ----------------------------------------------------------------------------
package cqg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_VERTICES = 4;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam longint ISQRT3_Q32 = 64'd2479700525;
  localparam longint SQRT35_Q32 = 64'd3326867362;
  localparam longint S3 = (ISQRT3_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint S9 = (SQRT35_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint SIXTH = (ONE_Q + 3) / 6;
  localparam longint TWO_THIRD = (2 * ONE_Q + 1) / 3;
  localparam longint W_TRI = (ONE_Q + 1) / 3;

  // coefficient table layout: triangle 3 points, quad 2x2, triangle 3x3, quad 3x3
  localparam int TAB_QUAD4 = 3;
  localparam int TAB_TRI9 = 7;
  localparam int TAB_QUAD9 = 16;
  localparam int TAB_SIZE = 25;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [16:0] point_weight;
    logic [30:0] jacobian;
    logic [30:0] cell_area;
    logic bad_shape;
    logic last_point;
  } point_t;

  typedef struct packed {
    logic [MAX_VERTICES-1:0][31:0] jx;
    logic [MAX_VERTICES-1:0][31:0] jy;
    logic quad;
    logic bad;
    logic mode;
  } job_t;

  typedef struct packed {
    logic [16:0] w;
    logic signed [18:0] nf0;
    logic signed [18:0] nf1;
    logic signed [18:0] nf2;
    logic signed [18:0] nf3;
    logic [17:0] oma;
    logic [17:0] opa;
    logic [17:0] omb;
    logic [17:0] opb;
  } coef_t;

  function automatic longint bilin(input longint fa, input longint fb);
    return (fa * fb + (longint'(1) << (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
  endfunction

  function automatic longint gcode(input longint i);
    return (i == 1) ? 64'd8 : 64'd5;
  endfunction

  function automatic coef_t coef_of(input int idx);
    coef_t c;
    longint a, b, w, k;
    logic is_quad;
    a = 0;
    b = 0;
    w = 0;
    k = 0;
    is_quad = 1'b0;
    if (idx < TAB_QUAD4) begin
      k = idx;
      a = (k == 1) ? TWO_THIRD : SIXTH;
      b = (k == 2) ? TWO_THIRD : SIXTH;
      w = W_TRI;
    end else if (idx < TAB_TRI9) begin
      k = idx - TAB_QUAD4;
      a = ((k & 2) != 0) ? S3 : -S3;
      b = ((k & 1) != 0) ? S3 : -S3;
      w = ONE_Q;
      is_quad = 1'b1;
    end else begin
      k = (idx < TAB_QUAD9) ? idx - TAB_TRI9 : idx - TAB_QUAD9;
      is_quad = (idx >= TAB_QUAD9);
      a = (k / 3 - 1) * S9;
      b = (k % 3 - 1) * S9;
      w = (2 * gcode(k / 3) * gcode(k % 3) * ONE_Q + 81) / 162;
    end
    c.w = 17'(w);
    if (is_quad) begin
      c.nf0 = 19'(bilin(ONE_Q - a, ONE_Q - b));
      c.nf1 = 19'(bilin(ONE_Q + a, ONE_Q - b));
      c.nf2 = 19'(bilin(ONE_Q + a, ONE_Q + b));
      c.nf3 = 19'(bilin(ONE_Q - a, ONE_Q + b));
    end else begin
      c.nf0 = 19'(ONE_Q - a - b);
      c.nf1 = 19'(a);
      c.nf2 = 19'(b);
      c.nf3 = 19'(0);
    end
    c.oma = 18'(ONE_Q - a);
    c.opa = 18'(ONE_Q + a);
    c.omb = 18'(ONE_Q - b);
    c.opb = 18'(ONE_Q + b);
    return c;
  endfunction

  localparam coef_t COEF_TABLE [0:TAB_SIZE-1] = '{
    coef_of(0), coef_of(1), coef_of(2), coef_of(3), coef_of(4),
    coef_of(5), coef_of(6), coef_of(7), coef_of(8), coef_of(9),
    coef_of(10), coef_of(11), coef_of(12), coef_of(13), coef_of(14),
    coef_of(15), coef_of(16), coef_of(17), coef_of(18), coef_of(19),
    coef_of(20), coef_of(21), coef_of(22), coef_of(23), coef_of(24)
  };

endpackage

/* src/cqg_fifo.sv */
// ----------------------------------------------------------------------------
// cqg_fifo: small register queue
// Holds whole words; head is shown while not empty.
// ----------------------------------------------------------------------------
module cqg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0] rptr, wptr;
  logic [CW-1:0] count;
  logic do_wr, do_rd;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr <= '0;
      wptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/cqg_front.sv */
// ----------------------------------------------------------------------------
// cqg_front: vertex capture and cell classification
// Collects vertices of the open cell and hands a finished cell on as a job.
// ----------------------------------------------------------------------------
module cqg_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  cqg_pkg::vertex_t vertex,
  input  logic             mode,
  output logic             job_push,
  output cqg_pkg::job_t    job
);

  logic [31:0] vx [0:cqg_pkg::MAX_VERTICES-1];
  logic [31:0] vy [0:cqg_pkg::MAX_VERTICES-1];
  logic [2:0] vertex_count;
  logic [2:0] n_new;

  assign n_new = (vertex_count < 3'd7) ? vertex_count + 3'd1 : 3'd7;
  assign job_push = accept && vertex.last_vertex;

  // snapshot including the vertex arriving now
  always_comb begin
    for (int i = 0; i < cqg_pkg::MAX_VERTICES; i++) begin
      if (!vertex_count[2] && vertex_count[1:0] == 2'(i)) begin
        job.jx[i] = vertex.vertex_x;
        job.jy[i] = vertex.vertex_y;
      end else begin
        job.jx[i] = vx[i];
        job.jy[i] = vy[i];
      end
    end
    job.quad = (n_new == 3'd4);
    job.bad = (n_new != 3'd3) && (n_new != 3'd4);
    job.mode = mode;
  end

  always_ff @(posedge clk) begin
    if (accept && !vertex_count[2]) begin
      vx[vertex_count[1:0]] <= vertex.vertex_x;
      vy[vertex_count[1:0]] <= vertex.vertex_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (accept) begin
      vertex_count <= vertex.last_vertex ? 3'd0 : n_new;
    end
  end

endmodule

/* src/cqg_back.sv */
// ----------------------------------------------------------------------------
// cqg_back: quadrature sequencer
// Runs one shared multiply-accumulate over area, points and Jacobians.
// ----------------------------------------------------------------------------
module cqg_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  cqg_pkg::job_t    job,
  output logic             job_pop,
  input  logic             res_full,
  output logic             res_push,
  output cqg_pkg::point_t  res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AREA  = 3'd1;
  localparam logic [2:0] ST_POINT = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  localparam logic [2:0] FIN_NONE = 3'd0;
  localparam logic [2:0] FIN_AREA = 3'd1;
  localparam logic [2:0] FIN_GX   = 3'd2;
  localparam logic [2:0] FIN_GY   = 3'd3;
  localparam logic [2:0] FIN_D0   = 3'd4;
  localparam logic [2:0] FIN_D1   = 3'd5;
  localparam logic [2:0] FIN_D2   = 3'd6;
  localparam logic [2:0] FIN_D3   = 3'd7;

  logic [2:0] state;
  logic [4:0] op;
  logic half;
  logic [3:0] k;
  logic [2:0] fin;
  logic signed [79:0] acc, acc_next;
  logic [30:0] area;
  logic signed [31:0] gx, gy;
  logic signed [35:0] d [0:3];

  logic signed [35:0] mul_a, mul_b;
  logic neg, clr;
  logic signed [18:0] mul_sel;
  logic signed [54:0] prod;
  logic signed [79:0] term;
  logic [4:0] cidx;
  logic [3:0] npts;
  logic last_k;
  logic [4:0] last_op;
  logic group_end;
  logic [2:0] fin_next;
  cqg_pkg::coef_t cf;

  function automatic logic signed [35:0] sx(input logic [31:0] v);
    return 36'($signed(v));
  endfunction

  function automatic logic signed [35:0] sn(input logic signed [18:0] v);
    return 36'(v);
  endfunction

  function automatic logic signed [31:0] gsat(input logic signed [79:0] v);
    logic signed [79:0] r;
    r = (v + 80'sd32768) >>> cqg_pkg::FRAC_BITS;
    if (!r[79] && r[78:31] != '0) begin
      return 32'sh7FFFFFFF;
    end else if (r[79] && r[78:31] != '1) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  function automatic logic [30:0] magsat(input logic signed [79:0] v, input int sh);
    logic [79:0] m;
    m = v[79] ? 80'(-v) : 80'(v);
    m = (m + (80'd1 << (sh - 1))) >> sh;
    if (m[79:31] != '0) begin
      return 31'h7FFFFFFF;
    end
    return m[30:0];
  endfunction

  assign npts = job.mode ? 4'd9 : (job.quad ? 4'd4 : 4'd3);
  assign last_k = (k == npts - 4'd1);
  assign cidx = job.mode ? ((job.quad ? 5'(cqg_pkg::TAB_QUAD9) : 5'(cqg_pkg::TAB_TRI9)) + 5'(k))
                         : ((job.quad ? 5'(cqg_pkg::TAB_QUAD4) : 5'd0) + 5'(k));
  assign cf = cqg_pkg::COEF_TABLE[cidx];

  // operand decode
  always_comb begin
    logic [1:0] v, j;
    logic signed [18:0] nfv;
    mul_a = '0;
    mul_b = '0;
    neg = 1'b0;
    clr = 1'b0;
    v = op[2:1];
    j = (!job.quad && v == 2'd2) ? 2'd0 : v + 2'd1;
    case (op[1:0])
      2'd0: nfv = cf.nf0;
      2'd1: nfv = cf.nf1;
      2'd2: nfv = cf.nf2;
      default: nfv = cf.nf3;
    endcase
    if (state == ST_AREA) begin
      clr = (op == 5'd0);
      if (!op[0]) begin
        mul_a = sx(job.jx[v]);
        mul_b = sx(job.jy[j]);
      end else begin
        mul_a = sx(job.jy[v]);
        mul_b = sx(job.jx[j]);
        neg = 1'b1;
      end
    end else if (!job.quad) begin
      clr = (op == 5'd0) || (op == 5'd3);
      case (op)
        5'd0: begin mul_a = sx(job.jx[0]); mul_b = sn(cf.nf0); end
        5'd1: begin mul_a = sx(job.jx[1]); mul_b = sn(cf.nf1); end
        5'd2: begin mul_a = sx(job.jx[2]); mul_b = sn(cf.nf2); end
        5'd3: begin mul_a = sx(job.jy[0]); mul_b = sn(cf.nf0); end
        5'd4: begin mul_a = sx(job.jy[1]); mul_b = sn(cf.nf1); end
        default: begin mul_a = sx(job.jy[2]); mul_b = sn(cf.nf2); end
      endcase
    end else begin
      clr = (op == 5'd0) || (op == 5'd4) || (op == 5'd8) || (op == 5'd10) ||
            (op == 5'd12) || (op == 5'd14) || (op == 5'd16);
      case (op)
        5'd0, 5'd1, 5'd2, 5'd3: begin
          mul_a = sx(job.jx[op[1:0]]);
          mul_b = sn(nfv);
        end
        5'd4, 5'd5, 5'd6, 5'd7: begin
          mul_a = sx(job.jy[op[1:0]]);
          mul_b = sn(nfv);
        end
        5'd8:  begin mul_a = sx(job.jx[1]) - sx(job.jx[0]); mul_b = 36'(cf.omb); end
        5'd9:  begin mul_a = sx(job.jx[2]) - sx(job.jx[3]); mul_b = 36'(cf.opb); end
        5'd10: begin mul_a = sx(job.jy[1]) - sx(job.jy[0]); mul_b = 36'(cf.omb); end
        5'd11: begin mul_a = sx(job.jy[2]) - sx(job.jy[3]); mul_b = 36'(cf.opb); end
        5'd12: begin mul_a = sx(job.jx[3]) - sx(job.jx[0]); mul_b = 36'(cf.oma); end
        5'd13: begin mul_a = sx(job.jx[2]) - sx(job.jx[1]); mul_b = 36'(cf.opa); end
        5'd14: begin mul_a = sx(job.jy[3]) - sx(job.jy[0]); mul_b = 36'(cf.oma); end
        5'd15: begin mul_a = sx(job.jy[2]) - sx(job.jy[1]); mul_b = 36'(cf.opa); end
        // d[3] lands while this product starts, so take it last
        5'd16: begin mul_a = d[2]; mul_b = d[1]; neg = 1'b1; end
        default: begin mul_a = d[0]; mul_b = d[3]; end
      endcase
    end
  end

  // two half products per multiply-accumulate: low 18 bits of B, then the rest
  assign mul_sel = half ? 19'($signed(mul_b[35:18])) : $signed({1'b0, mul_b[17:0]});
  assign prod = mul_a * mul_sel;
  assign term = half ? (80'(prod) <<< 18) : 80'(prod);
  assign acc_next = ((clr && !half) ? 80'sd0 : acc) + (neg ? -term : term);

  always_comb begin
    if (state == ST_AREA) begin
      last_op = job.quad ? 5'd7 : 5'd5;
    end else begin
      last_op = job.quad ? 5'd17 : 5'd5;
    end
    group_end = half;
    fin_next = FIN_NONE;
    if (state == ST_AREA) begin
      if (op == last_op) fin_next = FIN_AREA;
    end else if (!job.quad) begin
      if (op == 5'd2) fin_next = FIN_GX;
    end else begin
      case (op)
        5'd3: fin_next = FIN_GX;
        5'd7: fin_next = FIN_GY;
        5'd9: fin_next = FIN_D0;
        5'd11: fin_next = FIN_D1;
        5'd13: fin_next = FIN_D2;
        5'd15: fin_next = FIN_D3;
        default: fin_next = FIN_NONE;
      endcase
    end
  end

  // result assembly
  always_comb begin
    res = '0;
    if (state == ST_ERR) begin
      res.bad_shape = 1'b1;
      res.last_point = 1'b1;
    end else begin
      res.point_x = gx;
      res.point_y = job.quad ? gy : gsat(acc);
      res.point_weight = cf.w;
      res.jacobian = job.quad ? magsat(acc, cqg_pkg::FRAC_BITS + 4) : area;
      res.cell_area = area;
      res.last_point = last_k;
    end
  end

  assign res_push = ((state == ST_EMIT) || (state == ST_ERR)) && !res_full;
  assign job_pop = ((state == ST_EMIT) && !res_full && last_k) ||
                   ((state == ST_ERR) && !res_full);

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_AREA || state == ST_POINT) begin
      acc <= acc_next;
    end
    if (state == ST_POINT) begin
      case (fin)
        FIN_AREA: area <= magsat(acc, cqg_pkg::FRAC_BITS + 1);
        FIN_GX: gx <= gsat(acc);
        FIN_GY: gy <= gsat(acc);
        FIN_D0: d[0] <= 36'((acc + 80'sd32768) >>> cqg_pkg::FRAC_BITS);
        FIN_D1: d[1] <= 36'((acc + 80'sd32768) >>> cqg_pkg::FRAC_BITS);
        FIN_D2: d[2] <= 36'((acc + 80'sd32768) >>> cqg_pkg::FRAC_BITS);
        FIN_D3: d[3] <= 36'((acc + 80'sd32768) >>> cqg_pkg::FRAC_BITS);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= '0;
      half <= 1'b0;
      k <= '0;
      fin <= FIN_NONE;
    end else begin
      fin <= FIN_NONE;
      unique case (state)
        ST_IDLE: begin
          op <= '0;
          half <= 1'b0;
          k <= '0;
          if (job_valid) begin
            state <= job.bad ? ST_ERR : ST_AREA;
          end
        end
        ST_AREA, ST_POINT: begin
          half <= !half;
          if (group_end) begin
            fin <= fin_next;
            if (op == last_op) begin
              op <= '0;
              state <= (state == ST_AREA) ? ST_POINT : ST_EMIT;
            end else begin
              op <= op + 5'd1;
            end
          end
        end
        ST_EMIT: begin
          if (!res_full) begin
            if (last_k) begin
              state <= ST_IDLE;
            end else begin
              k <= k + 4'd1;
              state <= ST_POINT;
            end
          end
        end
        ST_ERR: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/cell_quadrature_geometry.sv */
// ----------------------------------------------------------------------------
// cell_quadrature_geometry: Gauss point setup for triangle and quad cells
// Takes cell vertices, returns global Gauss points, weights and Jacobians.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive vertex and push; a transfer happens when push is high
//   and full is low. Vertices of one cell come counterclockwise, the last one
//   with last_vertex set. Up to JOB_DEPTH finished cells wait for the back end.
//   Result queue: while empty is low the oldest point is on point; raise pop
//   to transfer it. last_point marks the final point of a cell; a cell of
//   other than 3 or 4 vertices gives a single result with bad_shape set.
//   cfg_write/cfg_data load quadrature_mode (0: 3 or 2x2 points, 1: 3x3).
// Timing:
//   Vertices transfer one per cycle while full is low. Per cell the single
//   shared multiplier does each multiply-accumulate as two half products,
//   first over the area, then over each Gauss point in turn.
// Reset clears vertex count, mode and both queues. A stalled result queue
// holds the back end in its emit step; cells keep arriving until the job
// queue fills.
// ----------------------------------------------------------------------------
module cell_quadrature_geometry #(
  parameter int JOB_DEPTH = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  cqg_pkg::vertex_t vertex,
  output logic             empty,
  input  logic             pop,
  output cqg_pkg::point_t  point,
  input  logic             cfg_write,
  input  logic             cfg_data
);

  logic quadrature_mode;
  logic accept;
  logic job_push, job_full, job_empty, job_pop;
  cqg_pkg::job_t job_in, job_head;
  logic res_push, res_full;
  cqg_pkg::point_t res;

  // hold the mode; the user must change it only while the block is idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      quadrature_mode <= 1'b0;
    end else if (cfg_write) begin
      quadrature_mode <= cfg_data;
    end
  end

  // stall vertices whenever no room is left for a finished cell
  assign full = job_full;
  assign accept = push && !job_full;

  cqg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .vertex   (vertex),
    .mode     (quadrature_mode),
    .job_push (job_push),
    .job      (job_in)
  );

  cqg_fifo #(
    .WIDTH ($bits(cqg_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .wdata (job_in),
    .full  (job_full),
    .rd    (job_pop),
    .rdata (job_head),
    .empty (job_empty)
  );

  cqg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  cqg_fifo #(
    .WIDTH ($bits(cqg_pkg::point_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .full  (res_full),
    .rd    (pop),
    .rdata (point),
    .empty (empty)
  );

  // a result transfer into the queue never meets a full queue
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result written into full queue");

  // the back end releases a cell only while one is queued
  assert property (@(posedge clk) disable iff (rst) job_pop |-> !job_empty)
    else $error("job released from empty queue");

  // an error result always closes its cell
  assert property (@(posedge clk) disable iff (rst)
    (!empty && point.bad_shape) |-> point.last_point)
    else $error("bad shape result without last_point");

  // nothing waits on the result side right after reset
  assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

/* dv/cell_quadrature_geometry_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cell_quadrature_geometry_test: self-checking bench for Gauss point setup
// Feeds triangle, quad and malformed cells through the vertex queue, predicts
// every Gauss point in wide fixed point and checks the result queue in order,
// under both quadrature modes and several idle and stall patterns.
// ----------------------------------------------------------------------------
module cell_quadrature_geometry_test;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    cqg_pkg::vertex_t v;
    bit      typed;   // expected result written in the table row
    cqg_pkg::point_t  want;
  } row_t;

  localparam int FRAC = 16;
  localparam longint UNIT = longint'(1) << FRAC;
  localparam logic [31:0] MX = 32'h7fffffff;
  localparam logic [31:0] MN = 32'h80000000;
  localparam logic [31:0] U1 = 32'h00010000;
  localparam logic [31:0] U2 = 32'h00020000;
  localparam cqg_pkg::point_t BAD_PT = '{point_x: '0, point_y: '0, point_weight: '0,
                                jacobian: '0, cell_area: '0, bad_shape: 1'b1,
                                last_point: 1'b1};
  localparam int DIR_ROWS = 22;
  localparam int DRAIN_CYCLES = 500;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  cqg_pkg::vertex_t vertex = '0;
  logic    empty;
  logic    pop = 1'b0;
  cqg_pkg::point_t  point;
  logic    cfg_write = 1'b0;
  logic    cfg_data = 1'b0;

  // Predictor state: the open cell and the mode register.
  longint  cell_x [4];
  longint  cell_y [4];
  int      cell_count;
  bit      quad_mode;
  cqg_pkg::point_t  pending_points [$];

  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;
  int      sent = 0;
  row_t    dir_tab [DIR_ROWS];

  cell_quadrature_geometry dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .vertex   (vertex),
    .empty    (empty),
    .pop      (pop),
    .point    (point),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up long after the slowest legal run would have finished.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers for the predictor
  // --------------------------------------------------------------------------
  // Divide by 2^sh, rounding to nearest with ties toward +inf.
  function automatic acc_t round_down_by(acc_t v, int sh);
    return (v + (acc_t'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Magnitude divided by 2^sh, rounded, clamped to 31 bits.
  function automatic logic [30:0] rounded_magnitude(acc_t v, int sh);
    acc_t m;
    m = (v < 0) ? -v : v;
    m = (m + (acc_t'(1) <<< (sh - 1))) >>> sh;
    return (m > acc_t'(32'h7fffffff)) ? 31'h7fffffff : m[30:0];
  endfunction

  function automatic logic [31:0] clamp_coord(acc_t v);
    if (v > acc_t'(longint'(32'sh7fffffff))) return 32'h7fffffff;
    if (v < -acc_t'(longint'(1) << 31)) return 32'h80000000;
    return v[31:0];
  endfunction

  // Bilinear shape factor (fa * fb) / 4, rounded.
  function automatic longint shape_quarter(longint fa, longint fb);
    return (fa * fb + (longint'(1) << (FRAC + 1))) >>> (FRAC + 2);
  endfunction

  function automatic logic [30:0] quad_jac_at(longint a, longint b);
    acc_t dpde, dqde, dpdn, dqdn;
    dpde = round_down_by(acc_t'(cell_x[1] - cell_x[0]) * (UNIT - b)
                       + acc_t'(cell_x[2] - cell_x[3]) * (UNIT + b), FRAC);
    dqde = round_down_by(acc_t'(cell_y[1] - cell_y[0]) * (UNIT - b)
                       + acc_t'(cell_y[2] - cell_y[3]) * (UNIT + b), FRAC);
    dpdn = round_down_by(acc_t'(cell_x[3] - cell_x[0]) * (UNIT - a)
                       + acc_t'(cell_x[2] - cell_x[1]) * (UNIT + a), FRAC);
    dqdn = round_down_by(acc_t'(cell_y[3] - cell_y[0]) * (UNIT - a)
                       + acc_t'(cell_y[2] - cell_y[1]) * (UNIT + a), FRAC);
    return rounded_magnitude(dpde * dqdn - dpdn * dqde, FRAC + 4);
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: take one accepted vertex, queue the Gauss points it closes.
  // --------------------------------------------------------------------------
  task automatic predict_vertex(cqg_pkg::vertex_t v);
    int n, npts, j;
    longint r3, r9, sixth, two_third, a, b, w, gx, gy;
    longint nf [4];
    longint gcode [3];
    acc_t shoelace;
    logic [30:0] area, jac;
    cqg_pkg::point_t p;
    r3 = (longint'(64'd2479700525) + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC);
    r9 = (longint'(64'd3326867362) + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC);
    sixth = (UNIT + 3) / 6;
    two_third = (2 * UNIT + 1) / 3;
    gcode = '{5, 8, 5};
    // store only the first four vertices; the count saturates at 7
    if (cell_count < 4) begin
      cell_x[cell_count] = longint'(v.vertex_x);
      cell_y[cell_count] = longint'(v.vertex_y);
    end
    if (cell_count < 7) cell_count++;
    if (!v.last_vertex) return;
    n = cell_count;
    cell_count = 0;
    if (n != 3 && n != 4) begin
      pending_points = {pending_points, BAD_PT};
      return;
    end
    shoelace = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      shoelace += acc_t'(cell_x[i]) * acc_t'(cell_y[j]) - acc_t'(cell_y[i]) * acc_t'(cell_x[j]);
    end
    area = rounded_magnitude(shoelace, FRAC + 1);
    npts = quad_mode ? 9 : n;
    for (int k = 0; k < npts; k++) begin
      if (quad_mode) begin
        a = longint'(k / 3 - 1) * r9;
        b = longint'(k % 3 - 1) * r9;
        w = (2 * gcode[k / 3] * gcode[k % 3] * UNIT + 81) / 162;
      end else if (n == 4) begin
        a = (k & 2) ? r3 : -r3;
        b = (k & 1) ? r3 : -r3;
        w = UNIT;
      end else begin
        a = (k == 1) ? two_third : sixth;
        b = (k == 2) ? two_third : sixth;
        w = (UNIT + 1) / 3;
      end
      if (n == 3) begin
        nf = '{UNIT - a - b, a, b, 0};
        jac = area;
      end else begin
        nf[0] = shape_quarter(UNIT - a, UNIT - b);
        nf[1] = shape_quarter(UNIT + a, UNIT - b);
        nf[2] = shape_quarter(UNIT + a, UNIT + b);
        nf[3] = shape_quarter(UNIT - a, UNIT + b);
        jac = quad_jac_at(a, b);
      end
      gx = 0;
      gy = 0;
      for (int i = 0; i < n; i++) begin
        gx += cell_x[i] * nf[i];
        gy += cell_y[i] * nf[i];
      end
      p.point_x = clamp_coord(round_down_by(acc_t'(gx), FRAC));
      p.point_y = clamp_coord(round_down_by(acc_t'(gy), FRAC));
      p.point_weight = w[16:0];
      p.jacobian = jac;
      p.cell_area = area;
      p.bad_shape = 1'b0;
      p.last_point = (k + 1 == npts);
      pending_points = {pending_points, p};
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall at random, or hold off for hold_cycles; check transfers.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cqg_pkg::point_t want;
    if (!rst && pop && !empty) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual %h", $realtime, point);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (point.point_x !== want.point_x) begin
          $display("%0t: point_x expected %h actual %h", $realtime, want.point_x,
                   point.point_x);
          errors++;
        end
        if (point.point_y !== want.point_y) begin
          $display("%0t: point_y expected %h actual %h", $realtime, want.point_y,
                   point.point_y);
          errors++;
        end
        if (point.point_weight !== want.point_weight) begin
          $display("%0t: point_weight expected %h actual %h", $realtime,
                   want.point_weight, point.point_weight);
          errors++;
        end
        if (point.jacobian !== want.jacobian) begin
          $display("%0t: jacobian expected %h actual %h", $realtime, want.jacobian,
                   point.jacobian);
          errors++;
        end
        if (point.cell_area !== want.cell_area) begin
          $display("%0t: cell_area expected %h actual %h", $realtime, want.cell_area,
                   point.cell_area);
          errors++;
        end
        if (point.bad_shape !== want.bad_shape) begin
          $display("%0t: bad_shape expected %b actual %b", $realtime, want.bad_shape,
                   point.bad_shape);
          errors++;
        end
        if (point.last_point !== want.last_point) begin
          $display("%0t: last_point expected %b actual %b", $realtime, want.last_point,
                   point.last_point);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one vertex and hold it until the transfer. When typed is set the
  // table's own expectation replaces the predicted point.
  task automatic send_vertex(cqg_pkg::vertex_t v, bit typed = 1'b0,
                             cqg_pkg::point_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    vertex <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_vertex(v);
    if (typed) begin
      pending_points[pending_points.size() - 1] = want;
    end
    sent++;
  endtask

  // Stop offering and wait until every predicted point has come back, then
  // leave room for a malformed cell still in flight.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    quad_mode = m;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? MX : MN;
      2: return 32'($urandom_range(2 * 400 * 65536)) - 32'(400 * 65536);
      default: return 32'($urandom_range(16 * 65536)) - 32'(8 * 65536);
    endcase
  endfunction

  // One random cell: mostly triangles and quads, sometimes a malformed count.
  task automatic send_random_cell();
    int n;
    cqg_pkg::vertex_t v;
    if ($urandom_range(99) < 85) n = $urandom_range(3, 4);
    else n = (n == 0 && $urandom_range(1)) ? $urandom_range(1, 2) : $urandom_range(5, 8);
    for (int i = 0; i < n; i++) begin
      v.vertex_x = pick_coord();
      v.vertex_y = pick_coord();
      v.last_vertex = (i == n - 1);
      send_vertex(v);
    end
  endtask

  function automatic cqg_pkg::vertex_t vtx(logic [31:0] x, logic [31:0] y, bit last);
    return '{vertex_x: x, vertex_y: y, last_vertex: last};
  endfunction

  initial begin
    cell_count = 0;
    quad_mode = 1'b0;
    // Directed cells in the reset mode: small and saturating triangles and
    // quads, then cells of one, two and five vertices that must be rejected.
    dir_tab = '{
      '{vtx(0, 0, 0), 0, '0}, '{vtx(U1, 0, 0), 0, '0}, '{vtx(0, U1, 1), 0, '0},
      '{vtx(MX, MX, 0), 0, '0}, '{vtx(MN, MX, 0), 0, '0}, '{vtx(MX, MN, 1), 0, '0},
      '{vtx(0, 0, 0), 0, '0}, '{vtx(U2, 0, 0), 0, '0}, '{vtx(U2, U2, 0), 0, '0},
      '{vtx(0, U2, 1), 0, '0},
      '{vtx(MN, MN, 0), 0, '0}, '{vtx(MX, MN, 0), 0, '0}, '{vtx(MX, MX, 0), 0, '0},
      '{vtx(MN, MX, 1), 0, '0},
      '{vtx(MX, MN, 1), 1, BAD_PT},
      '{vtx(U1, U2, 0), 0, '0}, '{vtx(MN, MX, 1), 1, BAD_PT},
      '{vtx(0, 0, 0), 0, '0}, '{vtx(U1, 0, 0), 0, '0}, '{vtx(U1, U1, 0), 0, '0},
      '{vtx(0, U1, 0), 0, '0}, '{vtx(MX, MX, 1), 1, BAD_PT}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_vertex(dir_tab[r].v, dir_tab[r].typed, dir_tab[r].want);
    drain_results();

    // Phase: no idling, 3x3 mode; the receiver holds off long enough for the
    // job queue to fill and full to rise while vertices keep coming.
    write_mode(1'b1);
    hold_cycles = 3000;
    while (sent < 100) send_random_cell();
    drain_results();

    // Phase: sender idles often, reset-style point counts.
    write_mode(1'b0);
    send_idle_pct = 57;
    while (sent < 180) send_random_cell();
    // sender pause mid-phase until everything has come back
    drain_results();
    while (sent < 200) send_random_cell();
    drain_results();

    // Phase: receiver stalls often, 3x3 mode.
    write_mode(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    while (sent < 280) send_random_cell();
    drain_results();

    // Phase: both sides idle at moderate rate.
    write_mode(1'b0);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    while (sent < 360) send_random_cell();
    drain_results();

    // Phase: 3x3 mode, no idling, then both idling.
    write_mode(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sent < 420) send_random_cell();
    send_idle_pct = 30;
    recv_stall_pct = 30;
    while (sent < 480) send_random_cell();
    drain_results();

    if (errors == 0 && pending_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
